[rtl/assert_macros.svh]
// shared assertion macros for the draw engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define MFB_ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, held off while reset is asserted
`define MFB_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[rtl/mfb_pkg.sv]
`default_nettype none

package mfb_pkg;

    localparam int COLUMNS_DEFAULT = 132;
    localparam int PAGES_DEFAULT   = 8;

    typedef enum logic [2:0] {
        CMD_POINT   = 3'd0,
        CMD_FILL    = 3'd1,
        CMD_OUTLINE = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_READ    = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_CLEAR,
        ST_READ
    } state_t;

    // request to the byte walker
    typedef struct packed {
        logic       start;
        logic       outline;
        logic [7:0] xs;
        logic [7:0] ys;
        logic [7:0] xe;
        logic [7:0] ye;
    } walk_req_t;

    // one store byte to modify
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] mask;
    } walk_slot_t;

endpackage

`default_nettype wire

[rtl/mfb_ram.sv]
`default_nettype none

module mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/mfb_walker.sv]
`default_nettype none
`include "assert_macros.svh"

module mfb_walker #(
    parameter int COLUMNS = mfb_pkg::COLUMNS_DEFAULT,
    parameter int PAGES   = mfb_pkg::PAGES_DEFAULT,
    localparam int CW = $clog2(COLUMNS),
    localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1,
    localparam int AW = CW + PW
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mfb_pkg::walk_req_t req,
    output mfb_pkg::walk_slot_t     slot,
    output logic [AW-1:0]           addr
);

    localparam logic [7:0]    COL_MAX  = 8'(COLUMNS - 1);
    localparam logic [7:0]    ROW_MAX  = 8'(PAGES * 8 - 1);
    localparam logic [PW-1:0] PAGE_TOP = PW'(PAGES - 1);

    logic          active_reg, active_next;
    logic          outline_reg;
    logic [7:0]    col_reg, col_next, col_hi_reg;
    logic [PW-1:0] bank_reg, bank_next, bank_lo_reg, bank_hi_reg;
    logic [7:0]    xs_reg, xe_reg, ys_reg, ye_reg;

    // clipped ranges of the new request
    logic [7:0] col_lo, col_top, col_hi, row_lo, row_top, row_hi;
    logic       empty;

    always_comb
    begin
        if (req.outline)
        begin
            col_lo  = (req.xs < req.xe) ? req.xs : req.xe;
            col_top = (req.xs < req.xe) ? req.xe : req.xs;
            row_lo  = (req.ys < req.ye) ? req.ys : req.ye;
            row_top = (req.ys < req.ye) ? req.ye : req.ys;
        end
        else
        begin
            col_lo  = req.xs;
            col_top = req.xe;
            row_lo  = req.ys;
            row_top = req.ye;
        end
        col_hi = (col_top > COL_MAX) ? COL_MAX : col_top;
        row_hi = (row_top > ROW_MAX) ? ROW_MAX : row_top;
        empty  = (col_lo > col_hi) || (row_lo > row_hi);
    end

    // walk columns outer, row banks inner
    always_comb
    begin
        active_next = active_reg;
        col_next    = col_reg;
        bank_next   = bank_reg;
        if (req.start)
        begin
            active_next = !empty;
            col_next    = col_lo;
            bank_next   = row_lo[PW+2:3];
        end
        else if (active_reg)
        begin
            if (bank_reg == bank_hi_reg)
            begin
                bank_next = bank_lo_reg;
                col_next  = col_reg + 8'd1;
                if (col_reg == col_hi_reg)
                begin
                    active_next = 1'b0;
                end
            end
            else
            begin
                bank_next = bank_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        bank_reg <= bank_next;
        if (req.start)
        begin
            outline_reg <= req.outline;
            col_hi_reg  <= col_hi;
            bank_lo_reg <= row_lo[PW+2:3];
            bank_hi_reg <= row_hi[PW+2:3];
            xs_reg      <= req.xs;
            xe_reg      <= req.xe;
            ys_reg      <= req.ys;
            ye_reg      <= req.ye;
        end
    end

    // row mask of the current byte; row 8*bank+k sits at bit 7-k
    logic       edge_col, inner_col;
    logic [7:0] row;

    always_comb
    begin
        row       = '0;
        edge_col  = !outline_reg || (col_reg == xs_reg) || (col_reg == xe_reg);
        inner_col = outline_reg && (col_reg > xs_reg) && (col_reg < xe_reg);
        slot.mask = '0;
        for (int k = 0; k < 8; k++)
        begin
            row = 8'({bank_reg, 3'(k)});
            slot.mask[7-k] = (edge_col && (row >= ys_reg) && (row <= ye_reg))
                          || (inner_col && ((row == ys_reg) || (row == ye_reg)));
        end
        slot.valid = active_reg;
        slot.last  = (bank_reg == bank_hi_reg) && (col_reg == col_hi_reg);
        addr       = {col_reg[CW-1:0], PAGE_TOP - bank_reg};
    end

    `MFB_ASSERT_NEXT(a_last_ends_walk, clk, rst_n, slot.valid && slot.last, !slot.valid)
    `MFB_ASSERT_IMPL(a_start_when_free, clk, rst_n, req.start, !active_reg)

endmodule

`default_nettype wire

[rtl/mono_framebuffer_draw_engine_top.sv]
// monochrome page frame store with point, fill, outline, clear and read commands
// input channel s_axis: one 48-bit command per transfer; output channel m_axis:
// one 8-bit result per command (the stored byte for a read, zero otherwise)
// the store is one byte per column and page, with row 0 at the top bit of the
// last page; all drawing is read-modify-write of store bytes through a
// synchronous ram with one read and one write port
// point, fill and outline walk the touched bytes at one byte per cycle
// (columns in range times pages spanned by the rows), pipelined as read then
// write; the result is registered when the walk ends, as the last byte's write
// commits, and the engine is back in idle with it
// read answers from the ram through a read state; clear all writes zero to
// every ram address (2048 at 132 x 8); unused command codes answer zero
// straight from idle
// one command is in flight at a time; a new one is taken while the previous
// result still sits in the output register, as long as that register drains
// after reset the same clearing sweep runs (2048 addresses at 132 x 8) with
// s_axis_tready low
// a stalled receiver holds the result in the output register; no new command
// is taken until that slot is free or being emptied
`default_nettype none
`include "assert_macros.svh"

module mono_framebuffer_draw_engine_top #(
    parameter int COLUMNS = mfb_pkg::COLUMNS_DEFAULT,
    parameter int PAGES   = mfb_pkg::PAGES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command[2:0], x_start[10:3], y_start[18:11], x_end[26:19], y_end[34:27],
    // pixel_on[35], read_column[43:36], read_page[46:44], zero pad[47]
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_data[7:0]
    output logic      [7:0]  m_axis_tdata
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW    = CW + PW;
    localparam int DEPTH = 1 << AW;

    // input field decode
    mfb_pkg::cmd_t in_cmd;
    logic [7:0]    in_xs, in_ys, in_xe, in_ye, in_rcol;
    logic          in_on;
    logic [2:0]    in_rpage;
    logic          in_accept;

    assign in_cmd   = mfb_pkg::cmd_t'(s_axis_tdata[2:0]);
    assign in_xs    = s_axis_tdata[10:3];
    assign in_ys    = s_axis_tdata[18:11];
    assign in_xe    = s_axis_tdata[26:19];
    assign in_ye    = s_axis_tdata[34:27];
    assign in_on    = s_axis_tdata[35];
    assign in_rcol  = s_axis_tdata[43:36];
    assign in_rpage = s_axis_tdata[46:44];

    mfb_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_data_reg, out_data_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic            on_reg, on_next;
    logic            read_ok_reg, read_ok_next;

    // write stage of the read-modify-write pipe
    logic            wr_valid_reg;
    logic [AW-1:0]   wr_addr_reg;
    logic [7:0]      wr_mask_reg;

    mfb_pkg::walk_req_t  walk_req;
    mfb_pkg::walk_slot_t walk_slot;
    logic [AW-1:0]       walk_addr;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    assign s_axis_tready = (state_reg == mfb_pkg::ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    mfb_walker #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (walk_req),
        .slot  (walk_slot),
        .addr  (walk_addr)
    );

    mfb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ram ports: sweep writes zero, otherwise the write stage merges the mask
    always_comb
    begin
        if ((state_reg == mfb_pkg::ST_INIT) || (state_reg == mfb_pkg::ST_CLEAR))
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = wr_valid_reg;
            ram_waddr = wr_addr_reg;
            ram_wdata = on_reg ? (ram_rdata | wr_mask_reg) : (ram_rdata & ~wr_mask_reg);
        end
        if (state_reg == mfb_pkg::ST_WALK)
        begin
            ram_raddr = walk_addr;
        end
        else
        begin
            ram_raddr = {in_rcol[CW-1:0], PW'(in_rpage)};
        end
    end

    // command sequencer
    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;
        clr_addr_next    = clr_addr_reg;
        on_next          = on_reg;
        read_ok_next     = read_ok_reg;
        walk_req.start   = 1'b0;
        walk_req.outline = 1'b0;
        walk_req.xs      = in_xs;
        walk_req.ys      = in_ys;
        walk_req.xe      = in_xe;
        walk_req.ye      = in_ye;

        unique case (state_reg)
            mfb_pkg::ST_INIT:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (&clr_addr_reg)
                begin
                    state_next = mfb_pkg::ST_IDLE;
                end
            end
            mfb_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    on_next = in_on;
                    unique case (in_cmd)
                        mfb_pkg::CMD_POINT:
                        begin
                            // a point is a one-pixel fill
                            walk_req.start = 1'b1;
                            walk_req.xe    = in_xs;
                            walk_req.ye    = in_ys;
                            state_next     = mfb_pkg::ST_WALK;
                        end
                        mfb_pkg::CMD_FILL:
                        begin
                            walk_req.start = 1'b1;
                            state_next     = mfb_pkg::ST_WALK;
                        end
                        mfb_pkg::CMD_OUTLINE:
                        begin
                            walk_req.start   = 1'b1;
                            walk_req.outline = 1'b1;
                            state_next       = mfb_pkg::ST_WALK;
                        end
                        mfb_pkg::CMD_CLEAR:
                        begin
                            state_next = mfb_pkg::ST_CLEAR;
                        end
                        mfb_pkg::CMD_READ:
                        begin
                            read_ok_next = (32'(in_rcol) < COLUMNS) && (32'(in_rpage) < PAGES);
                            state_next   = mfb_pkg::ST_READ;
                        end
                        default:
                        begin
                            // unused code: no effect, answer zero at once
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                        end
                    endcase
                end
            end
            mfb_pkg::ST_WALK:
            begin
                // last byte's write commits at the same edge
                if (!walk_slot.valid)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    state_next     = mfb_pkg::ST_IDLE;
                end
            end
            mfb_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (&clr_addr_reg)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    state_next     = mfb_pkg::ST_IDLE;
                end
            end
            mfb_pkg::ST_READ:
            begin
                out_valid_next = 1'b1;
                out_data_next  = read_ok_reg ? ram_rdata : '0;
                state_next     = mfb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mfb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfb_pkg::ST_INIT;
            out_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
            wr_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            clr_addr_reg  <= clr_addr_next;
            wr_valid_reg  <= walk_slot.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        on_reg       <= on_next;
        read_ok_reg  <= read_ok_next;
        wr_addr_reg  <= walk_addr;
        wr_mask_reg  <= walk_slot.mask;
    end

    `MFB_ASSERT_IMPL(a_walk_in_walk, clk, rst_n, walk_slot.valid, state_reg == mfb_pkg::ST_WALK)
    `MFB_ASSERT_IMPL(a_no_write_idle, clk, rst_n, ram_we, state_reg != mfb_pkg::ST_IDLE && state_reg != mfb_pkg::ST_READ)
    `MFB_ASSERT_NEXT(a_read_next, clk, rst_n, in_accept && in_cmd == mfb_pkg::CMD_READ, state_reg == mfb_pkg::ST_READ)

endmodule

`default_nettype wire
